FILE: hdl/fp2h_pkg.sv
// ---------------------------------------------------------------------------
// fp2h_pkg: shared constants and conversion function for the pair packer
// Holds the binary32 to binary16 conversion used for both lanes.
// ---------------------------------------------------------------------------
package fp2h_pkg;

  localparam logic [30:0] SGL_EXP_ALL_ONES = 31'h7f800000;
  localparam logic [15:0] HALF_QNAN        = 16'h7e00;
  localparam logic [15:0] HALF_INF         = 16'h7c00;
  localparam logic [23:0] SGL_HIDDEN       = 24'h800000;
  localparam logic [23:0] ROUND_HALF       = 24'h001000;
  localparam logic [10:0] HALF_MANT_CARRY  = 11'h400;
  localparam int          SGL_BIAS         = 127;
  localparam int          HALF_BIAS        = 15;
  localparam logic [9:0]  EXP_OFFSET       = 10'(SGL_BIAS - HALF_BIAS);

  typedef logic [15:0] half_t;

  // Convert one raw single to half; round half up in magnitude.
  function automatic half_t single_to_half(input logic [31:0] word);
    logic [15:0] sgn;
    logic [30:0] mag;
    logic [9:0]  e;      // rebased exponent, two's complement
    logic [4:0]  shamt;  // 1..11 in the subnormal range
    logic [23:0] sig;
    logic [23:0] sub;
    logic [24:0] sum;
    logic [10:0] m;
    logic [4:0]  he;
    half_t       res;
    sgn   = {word[31], 15'd0};
    mag   = word[30:0];
    e     = {2'b00, mag[30:23]} - EXP_OFFSET;
    sig   = SGL_HIDDEN | {1'b0, mag[22:0]};
    shamt = 5'd1 - e[4:0];
    sub   = sig >> shamt;
    sum   = {1'b0, sub} + {1'b0, ROUND_HALF};
    m     = 11'(({1'b0, mag[22:0]} + {1'b0, ROUND_HALF}) >> 13);
    he    = e[4:0];
    if (mag >= SGL_EXP_ALL_ONES) begin
      res = sgn | ((mag > SGL_EXP_ALL_ONES) ? HALF_QNAN : HALF_INF);
    end else if (e[9] || e == 10'd0) begin
      // subnormal range or underflow to signed zero
      if ($signed(e) < -10) res = sgn;
      else res = sgn | 16'(sum >> 13);
    end else if (e >= 10'd31) begin
      res = sgn | HALF_INF;
    end else if (m == HALF_MANT_CARRY) begin
      // mantissa carry bumps the exponent
      if (he == 5'd30) res = sgn | HALF_INF;
      else res = sgn | {1'b0, he + 5'd1, 10'd0};
    end else begin
      res = sgn | {1'b0, he, m[9:0]};
    end
    return res;
  endfunction

endpackage

FILE: hdl/float_pair_to_half_pack_unit.sv
// ---------------------------------------------------------------------------
// float_pair_to_half_pack_unit: two singles in, one packed half pair out
// Input register, single conversion pass, output register.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries first_single and second_single.
//   Output channel out_valid/out_ready carries packed_halves, with the first
//   converted value in bits 15:0 and the second in bits 31:16.
//   The input register takes the pair, then its conversion loads the result
//   register; out_valid rises once the result register holds the pair.
//   Throughput: one pair per cycle while out_ready is high; each stage is
//   one conversion deep.
//   Stall: when out_ready is low the pipeline holds; a stage accepts new data
//   whenever it is empty or the stage after it moves, so in_ready only drops
//   when both stages are full and the receiver stalls.
//   Reset: rst_n low clears both valid flags; no results are pending.
//   NaN gives signed quiet NaN, overflow gives infinity, inputs that are
//   subnormal flush to signed zero, ties round up in magnitude.
// ---------------------------------------------------------------------------
module float_pair_to_half_pack_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_first_single,
  input  logic [31:0] in_second_single,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_packed_halves
);

  logic        s1_valid_r;
  logic [31:0] s1_first_r;
  logic [31:0] s1_second_r;
  logic        s2_valid_r;
  logic [31:0] s2_data_r;
  logic        s2_ready;
  logic [31:0] s2_data_nxt;

  // stage handshakes
  assign s2_ready = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // conversion of both lanes
  assign s2_data_nxt = {fp2h_pkg::single_to_half(s1_second_r),
                        fp2h_pkg::single_to_half(s1_first_r)};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_first_r  <= in_first_single;
      s1_second_r <= in_second_single;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_packed_halves = s2_data_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_packed_halves)))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && !out_ready))
    else $error("input stalled without full pipeline");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> s2_valid_r)
    else $error("stage one transfer lost");
`endif

endmodule

FILE: sim/float_pair_to_half_pack_unit_tb.sv
// ---------------------------------------------------------------------------
// float_pair_to_half_pack_unit_tb: self-checking bench for the pair packer
// Drives pairs of raw singles through valid/ready, predicts the packed half
// pair for every input transfer, and compares each output transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module float_pair_to_half_pack_unit_tb;

  // Expected packed halves, one entry per input transfer
  class half_pair_board;
    logic [31:0] pending_packs[$];
    int          errors;
    int          matched;

    // Independent single-to-half conversion
    function automatic logic [15:0] to_half(logic [31:0] w);
      logic [15:0] sgn;
      logic [30:0] mag;
      int          ex;
      logic [23:0] sig;
      logic [31:0] sh;
      logic [13:0] mant;
      sgn = w[31] ? 16'h8000 : 16'h0000;
      mag = w[30:0];
      if (mag >= 31'h7f800000) return sgn | ((mag > 31'h7f800000) ? 16'h7e00 : 16'h7c00);
      ex = int'(mag[30:23]) - 127 + 15;
      sig = {1'b1, mag[22:0]};
      if (ex <= 0) begin
        if (ex < -10) return sgn;
        sh = 32'(sig) >> (1 - ex);
        return sgn | 16'((sh + 32'h1000) >> 13);
      end
      if (ex >= 31) return sgn | 16'h7c00;
      mant = 14'((25'(mag[22:0]) + 25'h1000) >> 13);
      if (mant == 14'h400) begin
        ex = ex + 1;
        mant = 14'd0;
        if (ex >= 31) return sgn | 16'h7c00;
      end
      return sgn | 16'(ex << 10) | 16'(mant[9:0]);
    endfunction

    function void note_pair(logic [31:0] a, logic [31:0] b);
      pending_packs.push_back({to_half(b), to_half(a)});
    endfunction

    function void check_pack(logic [31:0] got);
      logic [31:0] want;
      if (pending_packs.size() == 0) begin
        $display("%0t: unexpected transfer, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_packs.pop_front();
      if (want !== got) begin
        $display("%0t: packed_halves mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end else matched++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_first_single = 0;
  logic [31:0] in_second_single = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_packed_halves;

  half_pair_board board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;
  int  pairs_sent = 0;

  localparam int WATCHDOG_LIMIT = 5000;

  float_pair_to_half_pack_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_single(in_first_single), .in_second_single(in_second_single),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_packed_halves(out_packed_halves)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_pair(in_first_single, in_second_single);
      if (out_valid && out_ready) board.check_pack(out_packed_halves);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1;
    end
  end

  // Receiver: random stalls, or held off entirely
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_recv) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Random single with interesting exponents most of the time
  function automatic logic [31:0] pick_single();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0, 1, 2: w[30:23] = 8'($urandom_range(102, 142));   // subnormal and normal half range
      3:       w[30:23] = 8'($urandom_range(100, 113));   // subnormal edge
      4:       w[30:23] = 8'($urandom_range(140, 143));   // overflow edge
      5:       w[12:0]  = ($urandom_range(1)) ? 13'h1000 : 13'h0fff; // ties
      6:       w[22:13] = 10'h3ff;                        // mantissa carry
      default: ;
    endcase
    return w;
  endfunction

  // One input transfer with optional idle gaps beforehand
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_first_single <= a;
    in_second_single <= b;
    pairs_sent++;
    do @(posedge clk); while (!(in_ready && in_valid));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_packs.size() != 0 && !timed_out) @(posedge clk);
  endtask

  logic [31:0] directed[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
    32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0001, 32'h3f80_0000,
    32'h477f_e000, 32'h477f_f000, 32'h4780_0000, 32'h7f7f_ffff,
    32'h3880_0000, 32'h387f_f000, 32'h3380_0000, 32'h3300_0000,
    32'h3300_0001, 32'h32ff_ffff, 32'h0000_0001, 32'h807f_ffff,
    32'h3f80_1000, 32'hbf80_0fff, 32'h3f9f_f000, 32'h7fff_ffff
  };

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed corner values, each paired with the entry seven places later
    foreach (directed[i])
      send_pair(directed[i], directed[(i + 7) % directed.size()]);
    drain();

    // Back pressure: hold the receiver off while the sender keeps offering
    fork
      begin
        hold_recv <= 1;
        repeat (60) @(posedge clk);
        hold_recv <= 0;
      end
      repeat (20) send_pair(pick_single(), pick_single());
    join
    drain();

    // Random phases with different idle patterns
    for (int ph = 0; ph < 5 && !timed_out; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 290 && !timed_out; k++)
        send_pair(pick_single(), pick_single());
      drain();
    end
    repeat (5) @(posedge clk);

    $display("Sent %0d pairs: signed zeros, infinities, NaNs, ties, carries,",
             pairs_sent);
    $display("subnormal edges and random words under varied idle and stall.");
    if (board.errors == 0 && board.pending_packs.size() == 0 && !timed_out)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Timeout ends the run
  always @(posedge clk) begin
    if (timed_out) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: float_pair_to_half_pack_unit.f
hdl/fp2h_pkg.sv
hdl/float_pair_to_half_pack_unit.sv
sim/float_pair_to_half_pack_unit_tb.sv
